// File: rtl/core/csft_pkg.sv
package csft_pkg;

  // Table geometry
  localparam int SLOTS      = 1024;
  localparam int SLOT_W     = 10;
  localparam int CNT_W      = 11;
  localparam int MAX_WORDS  = 9;
  localparam int NODE_MAX   = 8;
  localparam int NODE_BITS  = 24;
  localparam int WIDX_W     = 4;

  // Configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 4;
  localparam int NPC_W      = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_NODES_PER_CELL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HAS_ID_WORD    = 2'd1;
  localparam logic [NPC_W-1:0]     NPC_RESET          = 4'd4;

  typedef enum logic [1:0] {
    ACT_ADD     = 2'd0,
    ACT_REMOVE  = 2'd1,
    ACT_REPLACE = 2'd2,
    ACT_READ    = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_INVALID = 2'd1,
    ST_FULL    = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  typedef struct packed {
    action_t               action;
    logic [SLOT_W-1:0]     cell_req;
    logic [NODE_BITS-1:0]  node_0;
    logic [NODE_BITS-1:0]  node_1;
    logic [NODE_BITS-1:0]  node_2;
    logic [NODE_BITS-1:0]  node_3;
    logic [NODE_BITS-1:0]  node_4;
    logic [NODE_BITS-1:0]  node_5;
    logic [NODE_BITS-1:0]  node_6;
    logic [NODE_BITS-1:0]  node_7;
    logic [NODE_BITS-1:0]  id_word;
  } req_t;

  typedef struct packed {
    status_t               status;
    logic [SLOT_W-1:0]     slot;
    logic [CNT_W-1:0]      live_count;
    logic [NODE_BITS-1:0]  word_0;
    logic [NODE_BITS-1:0]  word_1;
    logic [NODE_BITS-1:0]  word_2;
    logic [NODE_BITS-1:0]  word_3;
    logic [NODE_BITS-1:0]  word_4;
    logic [NODE_BITS-1:0]  word_5;
    logic [NODE_BITS-1:0]  word_6;
    logic [NODE_BITS-1:0]  word_7;
    logic [NODE_BITS-1:0]  word_id;
  } rsp_t;

  // Per-slot bookkeeping entry: occupancy flag and free-list link
  typedef struct packed {
    logic             used;
    logic [CNT_W-1:0] link;
  } slot_ent_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;
    logic commit;
  } ctrl_cmd_t;

  // Effective node words per tuple after clamping and fitting the id word
  function automatic logic [WIDX_W-1:0] node_count(input logic [NPC_W-1:0] npc,
                                                   input logic id);
    logic [WIDX_W-1:0] n;
    logic [WIDX_W-1:0] room;
    room = WIDX_W'(MAX_WORDS) - WIDX_W'(id);
    if (npc == '0) begin
      n = WIDX_W'(1);
    end else if (npc > NPC_W'(NODE_MAX)) begin
      n = WIDX_W'(NODE_MAX);
    end else begin
      n = WIDX_W'(npc);
    end
    if (n > room) begin
      n = room;
    end
    return n;
  endfunction

endpackage

// File: rtl/core/csft_ram.sv
module csft_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, holds data when not enabled
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/csft_ctrl.sv
module csft_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output csft_pkg::ctrl_cmd_t cmd
);

  csft_pkg::state_t state;
  csft_pkg::state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= csft_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    unique case (state)
      csft_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = csft_pkg::S_EXEC;
        end
      end
      csft_pkg::S_EXEC: begin
        // commit only when the output register is free or being drained
        if (!out_valid || out_ready) begin
          cmd.commit = 1'b1;
          state_next = csft_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = csft_pkg::S_IDLE;
      end
    endcase
  end

  // Output valid: set on commit, drop once the transaction is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.commit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

// File: rtl/core/csft_dp.sv
module csft_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  csft_pkg::ctrl_cmd_t                 cmd,
  input  csft_pkg::req_t                      in_data,
  output csft_pkg::rsp_t                      out_data,
  input  logic                                cfg_valid,
  input  logic [csft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csft_pkg::CFG_DATA_W-1:0]     cfg_data
);

  localparam int SW = csft_pkg::SLOT_W;
  localparam int CW = csft_pkg::CNT_W;
  localparam int NB = csft_pkg::NODE_BITS;
  localparam int MW = csft_pkg::MAX_WORDS;
  localparam int EW = $bits(csft_pkg::slot_ent_t);

  // Configuration registers
  logic [csft_pkg::NPC_W-1:0] nodes_per_cell;
  logic                       has_id_word;

  // Allocator state; high_water marks the start of the never-used linear tail
  logic [CW-1:0] free_head;
  logic [CW-1:0] high_water;
  logic [CW-1:0] occupied;
  logic [CW-1:0] free_head_next;
  logic [CW-1:0] high_water_next;
  logic [CW-1:0] occupied_next;

  csft_pkg::req_t req;
  csft_pkg::rsp_t rsp;

  // Memory ports
  logic                  ent_re;
  logic [SW-1:0]         ent_raddr;
  csft_pkg::slot_ent_t   ent_rd;
  logic                  ent_we;
  logic [SW-1:0]         ent_waddr;
  csft_pkg::slot_ent_t   ent_wd;
  logic [MW-1:0]         word_we;
  logic [SW-1:0]         word_waddr;
  logic [NB-1:0]         word_wd [MW];
  logic [NB-1:0]         word_rd [MW];
  logic [NB-1:0]         node_arr [MW];
  logic [NB-1:0]         out_words [csft_pkg::NODE_MAX];

  // Decode
  logic [csft_pkg::WIDX_W-1:0] n_words;
  logic                        full;
  logic                        in_tail;
  logic                        slot_ok;
  logic                        add_ok;
  logic                        rem_ok;
  logic                        rep_ok;
  logic                        rd_ok;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      nodes_per_cell <= csft_pkg::NPC_RESET;
      has_id_word    <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        csft_pkg::CFG_NODES_PER_CELL: nodes_per_cell <= cfg_data;
        csft_pkg::CFG_HAS_ID_WORD:    has_id_word    <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Hold the request for the execute cycle
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= in_data;
    end
  end

  // Issue slot entry and tuple reads on accept
  assign ent_re    = cmd.start;
  assign ent_raddr = (in_data.action == csft_pkg::ACT_ADD) ? free_head[SW-1:0]
                                                           : in_data.cell_req;

  csft_ram #(.WIDTH(EW), .DEPTH(csft_pkg::SLOTS)) u_ent_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wd),
    .re    (ent_re),
    .raddr (ent_raddr),
    .rdata (ent_rd)
  );

  for (genvar k = 0; k < MW; k++) begin : g_word
    csft_ram #(.WIDTH(NB), .DEPTH(csft_pkg::SLOTS)) u_word_ram (
      .clk   (clk),
      .we    (word_we[k]),
      .waddr (word_waddr),
      .wdata (word_wd[k]),
      .re    (cmd.start),
      .raddr (in_data.cell_req),
      .rdata (word_rd[k])
    );
  end

  // Decide the operation outcome
  always_comb begin
    n_words  = csft_pkg::node_count(nodes_per_cell, has_id_word);
    full     = free_head >= CW'(csft_pkg::SLOTS);
    in_tail  = free_head == high_water;
    slot_ok  = ({1'b0, req.cell_req} < high_water) && ent_rd.used;
    add_ok   = (req.action == csft_pkg::ACT_ADD) && !full;
    rem_ok   = (req.action == csft_pkg::ACT_REMOVE) && slot_ok;
    rep_ok   = (req.action == csft_pkg::ACT_REPLACE) && slot_ok;
    rd_ok    = (req.action == csft_pkg::ACT_READ) && slot_ok;
  end

  // Next allocator state
  always_comb begin
    free_head_next  = free_head;
    high_water_next = high_water;
    occupied_next   = occupied;
    if (add_ok) begin
      free_head_next = in_tail ? free_head + CW'(1) : ent_rd.link;
      if (in_tail) begin
        high_water_next = high_water + CW'(1);
      end
      occupied_next = occupied + CW'(1);
    end else if (rem_ok) begin
      free_head_next = {1'b0, req.cell_req};
      occupied_next  = occupied - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      free_head  <= '0;
      high_water <= '0;
      occupied   <= '0;
    end else if (cmd.commit) begin
      free_head  <= free_head_next;
      high_water <= high_water_next;
      occupied   <= occupied_next;
    end
  end

  // Slot entry writes: mark used on add, push on the free list on remove
  always_comb begin
    ent_we       = cmd.commit && (add_ok || rem_ok);
    ent_waddr    = add_ok ? free_head[SW-1:0] : req.cell_req;
    ent_wd.used  = add_ok;
    ent_wd.link  = free_head;
  end

  // Tuple writes: node words first, id word right after them
  always_comb begin
    node_arr = '{default: '0};
    node_arr[0] = req.node_0;
    node_arr[1] = req.node_1;
    node_arr[2] = req.node_2;
    node_arr[3] = req.node_3;
    node_arr[4] = req.node_4;
    node_arr[5] = req.node_5;
    node_arr[6] = req.node_6;
    node_arr[7] = req.node_7;
    word_waddr  = add_ok ? free_head[SW-1:0] : req.cell_req;
    for (int k = 0; k < MW; k++) begin
      word_we[k] = cmd.commit && (add_ok || rep_ok) &&
                   ((csft_pkg::WIDX_W'(k) < n_words) ||
                    (has_id_word && (csft_pkg::WIDX_W'(k) == n_words)));
      word_wd[k] = (csft_pkg::WIDX_W'(k) < n_words) ? node_arr[k] : req.id_word;
    end
  end

  // Build the result
  always_comb begin
    for (int k = 0; k < csft_pkg::NODE_MAX; k++) begin
      out_words[k] = (rd_ok && (csft_pkg::WIDX_W'(k) < n_words)) ? word_rd[k] : '0;
    end
    rsp = '0;
    if (req.action == csft_pkg::ACT_ADD) begin
      rsp.status = full ? csft_pkg::ST_FULL : csft_pkg::ST_OK;
      rsp.slot   = full ? '0 : free_head[SW-1:0];
    end else begin
      rsp.status = slot_ok ? csft_pkg::ST_OK : csft_pkg::ST_INVALID;
      rsp.slot   = req.cell_req;
    end
    rsp.live_count = occupied_next;
    rsp.word_0     = out_words[0];
    rsp.word_1     = out_words[1];
    rsp.word_2     = out_words[2];
    rsp.word_3     = out_words[3];
    rsp.word_4     = out_words[4];
    rsp.word_5     = out_words[5];
    rsp.word_6     = out_words[6];
    rsp.word_7     = out_words[7];
    rsp.word_id    = (rd_ok && has_id_word) ? word_rd[n_words] : '0;
  end

  // Output register
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_data <= rsp;
    end
  end

endmodule

// File: rtl/core/cell_slot_table_free_list.sv
// Result: registered at commit in the execute state that follows acceptance;
// commit waits while an earlier result still waits at the output.
// Acceptance: no new transaction until the current one commits, as each
// operation reads then writes the slot entry memory (free-list link and used flag).
// A waiting result does not block acceptance of the next transaction.
// Reset: synchronous, active high; no clearing pass, the table is usable at
// once (never-used slots are tracked by a high-water mark).
module cell_slot_table_free_list (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  csft_pkg::req_t                      in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output csft_pkg::rsp_t                      out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [csft_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [csft_pkg::CFG_DATA_W-1:0]     cfg_data
);

  csft_pkg::ctrl_cmd_t cmd;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  csft_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  csft_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .in_data   (in_data),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

endmodule
